@@ rtl/core/lkv_pkg.sv @@
package lkv_pkg;

  // table geometry
  localparam int unsigned MaxEntries = 16;
  localparam int unsigned IdxW       = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
  localparam int unsigned CntW       = $clog2(MaxEntries + 1);

  // field widths
  localparam int unsigned KeyW = 32;
  localparam int unsigned ValW = 32;
  localparam int unsigned CapW = 5;

  // capacity after reset
  localparam logic [CapW-1:0] CapReset = CapW'(16);

  // value returned by a get that misses
  localparam logic [ValW-1:0] MissValue = '1;

  typedef logic [IdxW-1:0] idx_t;
  typedef logic [CntW-1:0] cnt_t;

  // operations on the recency lanes
  typedef enum logic [1:0] {
    RankNop    = 2'd0,
    RankTouch  = 2'd1,
    RankEvict  = 2'd2,
    RankInsert = 2'd3
  } rank_op_e;

  typedef struct packed {
    rank_op_e op;
    idx_t     slot;
  } rank_cmd_t;

  typedef struct packed {
    logic [MaxEntries-1:0] valid;
    cnt_t                  occ;
    idx_t                  free_slot;
  } rank_stat_t;

endpackage

@@ rtl/core/lru_key_value_cache_top.sv @@
// key-value cache with lru replacement, one get or put per start
// the done strobe follows the key scan and a resolve step for a get or a put
// that hits; a put of a new key adds an insert step, with an evict step before it when needed
// a new start is taken only while the sequencer is idle, not during the key scan through the
// single-read-port key memory, one entry a cycle; start may be taken while done shows
// reset: async active low, empties the cache and sets capacity to 16; no stall on results
module lru_key_value_cache_top
  import lkv_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // command side
  input  logic                   start_i,
  output logic                   busy_o,
  input  logic                   mode_i,
  input  logic signed [KeyW-1:0] key_i,
  input  logic signed [ValW-1:0] value_i,
  // result side, one cycle strobe
  output logic                   done_o,
  output logic                   found_o,
  output logic signed [ValW-1:0] read_value_o,
  // capacity register
  input  logic                   cfg_we_i,
  input  logic [CapW-1:0]        cfg_wdata_i
);

  // one-hot sequencer states
  typedef enum logic [4:0] {
    StIdle    = 5'b00001,
    StScan    = 5'b00010,
    StResolve = 5'b00100,
    StEvict   = 5'b01000,
    StInsert  = 5'b10000
  } state_e;

  localparam int unsigned CmpW = (CntW > CapW) ? CntW : CapW;

  state_e          state_q, state_d;
  logic            accept;

  // item captured at the start transfer
  logic            mode_q;
  logic [KeyW-1:0] key_q;
  logic [ValW-1:0] value_q;

  // scan pipeline: read address counter, then compare stage in the next cycle
  cnt_t            rd_cnt_q, rd_cnt_d;
  logic            cmp_vld_q, cmp_vld_d;
  idx_t            cmp_idx_q, cmp_idx_d;
  idx_t            rd_addr;
  logic            match;
  logic            scan_last;

  // search outcome
  logic            hit_q, hit_d;
  idx_t            hit_idx_q, hit_idx_d;
  logic [ValW-1:0] hit_val_q, hit_val_d;

  // result register
  logic            done_q, done_d;
  logic            found_q, found_d;
  logic [ValW-1:0] rdval_q, rdval_d;

  // capacity
  logic [CapW-1:0] cap_q;
  logic [CmpW-1:0] cap_ext;
  logic [CmpW-1:0] eff_cap;
  logic            need_evict;

  // store and recency interfaces
  logic            wr_en;
  idx_t            wr_addr;
  logic [KeyW-1:0] rd_key;
  logic [ValW-1:0] rd_value;
  rank_cmd_t       rank_cmd;
  rank_stat_t      rank_stat;

  assign busy_o  = (state_q != StIdle);
  assign accept  = start_i && !busy_o;
  assign rd_addr = rd_cnt_q[IdxW-1:0];

  lkv_store u_store (
    .clk_i      (clk_i),
    .rd_addr_i  (rd_addr),
    .wr_en_i    (wr_en),
    .wr_addr_i  (wr_addr),
    .wr_key_i   (key_q),
    .wr_value_i (value_q),
    .rd_key_o   (rd_key),
    .rd_value_o (rd_value)
  );

  lkv_recency u_recency (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (rank_cmd),
    .stat_o (rank_stat)
  );

  // capacity zero acts as one, anything above the table size as the table size
  always_comb begin
    cap_ext = CmpW'(cap_q);
    if (cap_ext == '0) begin
      eff_cap = CmpW'(1);
    end else if (cap_ext > CmpW'(MaxEntries)) begin
      eff_cap = CmpW'(MaxEntries);
    end else begin
      eff_cap = cap_ext;
    end
  end

  // a lowered capacity evicts one entry per new key, never several at once
  assign need_evict = (CmpW'(rank_stat.occ) >= eff_cap);

  // shared key comparator, fed by the registered memory read
  assign match     = cmp_vld_q && rank_stat.valid[cmp_idx_q] && (rd_key == key_q);
  assign scan_last = cmp_vld_q && (cmp_idx_q == idx_t'(MaxEntries - 1));

  always_comb begin
    state_d       = state_q;
    rd_cnt_d      = rd_cnt_q;
    cmp_vld_d     = 1'b0;
    cmp_idx_d     = cmp_idx_q;
    hit_d         = hit_q;
    hit_idx_d     = hit_idx_q;
    hit_val_d     = hit_val_q;
    done_d        = 1'b0;
    found_d       = found_q;
    rdval_d       = rdval_q;
    rank_cmd.op   = RankNop;
    rank_cmd.slot = hit_idx_q;
    wr_en         = 1'b0;
    wr_addr       = hit_idx_q;

    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          state_d  = StScan;
          rd_cnt_d = '0;
          hit_d    = 1'b0;
        end
      end
      StScan: begin
        if (rd_cnt_q < cnt_t'(MaxEntries)) begin
          cmp_vld_d = 1'b1;
          cmp_idx_d = rd_addr;
          rd_cnt_d  = rd_cnt_q + cnt_t'(1);
        end
        // keys are unique among valid entries, keep the first match
        if (match && !hit_q) begin
          hit_d     = 1'b1;
          hit_idx_d = cmp_idx_q;
          hit_val_d = rd_value;
        end
        if (scan_last) begin
          state_d = StResolve;
        end
      end
      StResolve: begin
        if (hit_q) begin
          // hit: refresh recency, put also overwrites the value
          rank_cmd.op = RankTouch;
          wr_en       = mode_q;
          found_d     = 1'b1;
          rdval_d     = mode_q ? value_q : hit_val_q;
          done_d      = 1'b1;
          state_d     = StIdle;
        end else if (!mode_q) begin
          // get miss
          found_d = 1'b0;
          rdval_d = MissValue;
          done_d  = 1'b1;
          state_d = StIdle;
        end else if (need_evict) begin
          state_d = StEvict;
        end else begin
          state_d = StInsert;
        end
      end
      StEvict: begin
        rank_cmd.op = RankEvict;
        state_d     = StInsert;
      end
      StInsert: begin
        // new key goes to the lowest free slot as the most recent entry
        rank_cmd.op = RankInsert;
        wr_en       = 1'b1;
        wr_addr     = rank_stat.free_slot;
        found_d     = 1'b0;
        rdval_d     = value_q;
        done_d      = 1'b1;
        state_d     = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      rd_cnt_q  <= '0;
      cmp_vld_q <= 1'b0;
      hit_q     <= 1'b0;
      done_q    <= 1'b0;
      cap_q     <= CapReset;
    end else begin
      state_q   <= state_d;
      rd_cnt_q  <= rd_cnt_d;
      cmp_vld_q <= cmp_vld_d;
      hit_q     <= hit_d;
      done_q    <= done_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q  <= mode_i;
      key_q   <= key_i;
      value_q <= value_i;
    end
    cmp_idx_q <= cmp_idx_d;
    hit_idx_q <= hit_idx_d;
    hit_val_q <= hit_val_d;
    found_q   <= found_d;
    rdval_q   <= rdval_d;
  end

  assign done_o       = done_q;
  assign found_o      = found_q;
  assign read_value_o = rdval_q;

  // the done strobe only appears once the sequencer is back in idle
  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("done strobe while busy");

  // a start transfer always leads to a scan
  a_accept_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == StScan))
    else $error("start transfer did not begin a scan");

  // occupancy tracks the number of valid entries
  a_occ_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(rank_stat.valid) == int'(rank_stat.occ))
    else $error("occupancy out of step with valid entries");

  // an insert always has a free slot to land in
  a_insert_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StInsert) |-> !rank_stat.valid[rank_stat.free_slot])
    else $error("insert without a free slot");

endmodule

@@ rtl/core/lkv_store.sv @@
module lkv_store
  import lkv_pkg::*;
(
  input  logic            clk_i,
  input  idx_t            rd_addr_i,
  input  logic            wr_en_i,
  input  idx_t            wr_addr_i,
  input  logic [KeyW-1:0] wr_key_i,
  input  logic [ValW-1:0] wr_value_i,
  output logic [KeyW-1:0] rd_key_o,
  output logic [ValW-1:0] rd_value_o
);

  logic [KeyW-1:0] key_mem [MaxEntries];
  logic [ValW-1:0] val_mem [MaxEntries];
  logic [KeyW-1:0] rd_key_q;
  logic [ValW-1:0] rd_value_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      key_mem[wr_addr_i] <= wr_key_i;
      val_mem[wr_addr_i] <= wr_value_i;
    end
    rd_key_q   <= key_mem[rd_addr_i];
    rd_value_q <= val_mem[rd_addr_i];
  end

  assign rd_key_o   = rd_key_q;
  assign rd_value_o = rd_value_q;

endmodule

@@ rtl/core/lkv_recency.sv @@
module lkv_recency
  import lkv_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  rank_cmd_t  cmd_i,
  output rank_stat_t stat_o
);

  logic [MaxEntries-1:0] valid_q, valid_d;
  idx_t                  rank_q [MaxEntries];
  idx_t                  rank_d [MaxEntries];
  cnt_t                  occ_q, occ_d;
  cnt_t                  oldest_rank;
  idx_t                  free_slot;
  idx_t                  victim;
  idx_t                  touch_rank;

  // ranks of valid entries are distinct 0 .. occ-1, so the oldest has rank occ-1
  always_comb begin
    oldest_rank = occ_q - cnt_t'(1);
    free_slot   = '0;
    victim      = '0;
    for (int i = MaxEntries - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_slot = idx_t'(i);
      end
      if (valid_q[i] && (cnt_t'(rank_q[i]) == oldest_rank)) begin
        victim = idx_t'(i);
      end
    end
  end

  assign touch_rank = rank_q[cmd_i.slot];

  always_comb begin
    valid_d = valid_q;
    rank_d  = rank_q;
    occ_d   = occ_q;
    unique case (cmd_i.op)
      RankTouch: begin
        for (int i = 0; i < MaxEntries; i++) begin
          if (valid_q[i] && (rank_q[i] < touch_rank)) begin
            rank_d[i] = rank_q[i] + idx_t'(1);
          end
        end
        rank_d[cmd_i.slot] = '0;
      end
      RankEvict: begin
        valid_d[victim] = 1'b0;
        rank_d[victim]  = '0;
        occ_d           = occ_q - cnt_t'(1);
      end
      RankInsert: begin
        for (int i = 0; i < MaxEntries; i++) begin
          if (valid_q[i]) begin
            rank_d[i] = rank_q[i] + idx_t'(1);
          end
        end
        valid_d[free_slot] = 1'b1;
        rank_d[free_slot]  = '0;
        occ_d              = occ_q + cnt_t'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      occ_q   <= '0;
      for (int i = 0; i < MaxEntries; i++) begin
        rank_q[i] <= '0;
      end
    end else begin
      valid_q <= valid_d;
      occ_q   <= occ_d;
      rank_q  <= rank_d;
    end
  end

  assign stat_o.valid     = valid_q;
  assign stat_o.occ       = occ_q;
  assign stat_o.free_slot = free_slot;

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import lkv_pkg::*;

  localparam logic ModeGet = 1'b0;
  localparam logic ModePut = 1'b1;

  localparam int unsigned IdleLimit  = 2000; // cycles with no transfer before giving up
  localparam int unsigned PhaseItems = 90;
  localparam int unsigned NumPhases  = 10;
  localparam int unsigned PoolMax    = 24;
  localparam int unsigned PrintMax   = 40;

  // one result as the block reports it
  typedef struct packed {
    logic            found;
    logic [ValW-1:0] value;
  } lookup_t;

  typedef enum logic [1:0] {
    DoGet = 2'd0,
    DoPut = 2'd1,
    DoCap = 2'd2
  } row_kind_e;

  // directed row: a get, a put, or a capacity write (capacity in data)
  typedef struct packed {
    row_kind_e       kind;
    logic [KeyW-1:0] key;
    logic [ValW-1:0] data;
    logic            typed;
    logic            exp_found;
    logic [ValW-1:0] exp_value;
  } stim_row_t;

  // dut ports
  logic                   clk_i;
  logic                   rst_ni;
  logic                   start_i;
  logic                   busy_o;
  logic                   mode_i;
  logic signed [KeyW-1:0] key_i;
  logic signed [ValW-1:0] value_i;
  logic                   done_o;
  logic                   found_o;
  logic signed [ValW-1:0] read_value_o;
  logic                   cfg_we_i;
  logic [CapW-1:0]        cfg_wdata_i;

  // shadow copy of the cache contents, ages and capacity
  logic [KeyW-1:0] cached_key [MaxEntries];
  logic [ValW-1:0] cached_val [MaxEntries];
  bit              slot_used  [MaxEntries];
  int unsigned     slot_age   [MaxEntries];
  int unsigned     fill_count;
  logic [CapW-1:0] cap_setting;

  // results still owed by the block, oldest first
  lookup_t pending_results [$];

  stim_row_t   directed_rows [$];
  logic [KeyW-1:0] key_pool [PoolMax];
  int unsigned pool_n;
  int unsigned gap_max;

  int unsigned errors;
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned hits_seen;
  int unsigned cap_writes;
  int unsigned idle_cycles;

  lru_key_value_cache_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .mode_i       (mode_i),
    .key_i        (key_i),
    .value_i      (value_i),
    .done_o       (done_o),
    .found_o      (found_o),
    .read_value_o (read_value_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  // 20 ns clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // slot s becomes the most recent; everything newer than it ages by one
  function automatic void make_newest(input int s);
    int unsigned r;
    int i;
    r = slot_age[s];
    for (i = 0; i < MaxEntries; i++) begin
      if (slot_used[i] && slot_age[i] < r) slot_age[i]++;
    end
    slot_age[s] = 0;
  endfunction

  // applies one get or put to the shadow cache and returns what the block should report
  function automatic lookup_t cache_access(input logic m, input logic [KeyW-1:0] k,
                                           input logic [ValW-1:0] v);
    int          hit;
    int          victim;
    int          slot;
    int          i;
    int unsigned lim;
    lookup_t     res;
    hit = -1;
    for (i = 0; i < MaxEntries; i++) begin
      if (hit < 0 && slot_used[i] && cached_key[i] == k) hit = i;
    end
    if (m == ModeGet) begin
      if (hit >= 0) begin
        make_newest(hit);
        res.found = 1'b1;
        res.value = cached_val[hit];
      end else begin
        res.found = 1'b0;
        res.value = MissValue;
      end
      return res;
    end
    res.found = (hit >= 0);
    res.value = v;
    if (hit >= 0) begin
      cached_val[hit] = v;
      make_newest(hit);
      return res;
    end
    // capacity 0 acts as 1, anything above the table size as the table size
    lim = (cap_setting == 0) ? 1 : (cap_setting > MaxEntries) ? MaxEntries : cap_setting;
    if (fill_count >= lim) begin
      victim = -1;
      for (i = 0; i < MaxEntries; i++) begin
        if (slot_used[i] && (victim < 0 || slot_age[i] > slot_age[victim])) victim = i;
      end
      if (victim >= 0) begin
        slot_used[victim] = 1'b0;
        slot_age[victim]  = 0;
        if (fill_count > 0) fill_count--;
      end
    end
    slot = -1;
    for (i = 0; i < MaxEntries; i++) begin
      if (slot < 0 && !slot_used[i]) slot = i;
    end
    if (slot >= 0) begin
      for (i = 0; i < MaxEntries; i++) begin
        if (slot_used[i]) slot_age[i]++;
      end
      cached_key[slot] = k;
      cached_val[slot] = v;
      slot_used[slot]  = 1'b1;
      slot_age[slot]   = 0;
      fill_count++;
    end
    return res;
  endfunction

  // one command transfer: optional idle gap, then hold start until the block takes it
  task automatic send_op(input logic m, input logic [KeyW-1:0] k, input logic [ValW-1:0] v,
                         input logic typed, input logic ef, input logic [ValW-1:0] ev);
    int unsigned gap;
    bit          late;
    lookup_t     pred;
    gap  = $urandom_range(0, gap_max);
    // a late gap only counts cycles where the block is free, so it lands after busy drops
    late = $urandom_range(0, 1);
    while (gap > 0) begin
      @(negedge clk_i);
      start_i <= 1'b0;
      if (!(late && busy_o)) gap--;
    end
    @(negedge clk_i);
    start_i <= 1'b1;
    mode_i  <= m;
    key_i   <= k;
    value_i <= v;
    do @(posedge clk_i); while (busy_o);
    // transfer taken at this edge
    pred = cache_access(m, k, v);
    if (typed) begin
      pred.found = ef;
      pred.value = ev;
    end
    pending_results.push_back(pred);
    items_sent++;
  endtask

  // capacity write with the block idle and nothing outstanding
  task automatic set_capacity(input logic [CapW-1:0] c);
    @(negedge clk_i);
    start_i <= 1'b0;
    while (pending_results.size() > 0 || busy_o) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= c;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    cap_setting = c;
    cap_writes++;
  endtask

  // result checker and watchdog, sampled on the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || done_o) idle_cycles = 0;
      else idle_cycles++;
      if (done_o) begin
        results_seen++;
        if (found_o) hits_seen++;
        if (pending_results.size() == 0) begin
          errors++;
          if (errors <= PrintMax)
            $display("%0t: unexpected result found=%0b value=%h", $time, found_o,
                     read_value_o);
        end else begin
          if (found_o !== pending_results[0].found) begin
            errors++;
            if (errors <= PrintMax)
              $display("%0t: found mismatch, expected %0b actual %0b", $time,
                       pending_results[0].found, found_o);
          end
          if (read_value_o !== pending_results[0].value) begin
            errors++;
            if (errors <= PrintMax)
              $display("%0t: read_value mismatch, expected %h actual %h", $time,
                       pending_results[0].value, read_value_o);
          end
          void'(pending_results.pop_front());
        end
      end
      if (idle_cycles >= IdleLimit) begin
        $display("%0t: no transfer for %0d cycles, %0d results outstanding", $time,
                 idle_cycles, pending_results.size());
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    int unsigned     p;
    int unsigned     n;
    int unsigned     r;
    logic [CapW-1:0] cap;
    logic [CapW-1:0] cap_list [NumPhases];
    logic [KeyW-1:0] k;

    // every input known from time zero
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    mode_i      = ModeGet;
    key_i       = '0;
    value_i     = '0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;

    // shadow state after reset: empty, capacity 16
    for (r = 0; r < MaxEntries; r++) begin
      cached_key[r] = '0;
      cached_val[r] = '0;
      slot_used[r]  = 1'b0;
      slot_age[r]   = 0;
    end
    fill_count  = 0;
    cap_setting = CapReset;
    errors       = 0;
    items_sent   = 0;
    results_seen = 0;
    hits_seen    = 0;
    cap_writes   = 0;
    idle_cycles  = 0;
    gap_max      = 6;

    // capacity per random phase: extremes, clamped values, and some in between
    cap_list = '{5'd1, 5'd31, 5'd4, 5'd0, 5'd16, 5'd2, 5'd9, 5'd17, 5'd12, 5'd3};

    // directed part: extreme keys and values, miss, hit, update, hit on stored -1,
    // capacity lowered below occupancy, capacity zero, capacity above the table size
    directed_rows = '{
      '{DoGet, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, MissValue},
      '{DoGet, 32'h8000_0000, 32'h1234_5678, 1'b1, 1'b0, MissValue},
      '{DoPut, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b0, 32'h7FFF_FFFF},
      '{DoPut, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b0, 32'h8000_0000},
      '{DoPut, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
      '{DoPut, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'hFFFF_FFFF},
      '{DoGet, 32'h8000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'h7FFF_FFFF},
      '{DoGet, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 1'b1, 32'h8000_0000},
      '{DoGet, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b1, 32'hFFFF_FFFF},
      '{DoPut, 32'h0000_0000, 32'h5A5A_5A5A, 1'b1, 1'b1, 32'h5A5A_5A5A},
      '{DoGet, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'h5A5A_5A5A},
      '{DoGet, 32'h0000_0001, 32'h0000_0000, 1'b1, 1'b0, MissValue},
      '{DoCap, 32'h0000_0000, 32'h0000_0002, 1'b0, 1'b0, 32'h0},
      '{DoPut, 32'h0000_0011, 32'hA5A5_A5A5, 1'b0, 1'b0, 32'h0},
      '{DoGet, 32'h8000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
      '{DoPut, 32'h0000_0022, 32'h1234_5678, 1'b0, 1'b0, 32'h0},
      '{DoGet, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
      '{DoGet, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
      '{DoCap, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
      '{DoPut, 32'h0000_0033, 32'hC3C3_C3C3, 1'b0, 1'b0, 32'h0},
      '{DoGet, 32'h0000_0022, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
      '{DoGet, 32'h0000_0033, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
      '{DoCap, 32'h0000_0000, 32'h0000_001F, 1'b0, 1'b0, 32'h0},
      '{DoPut, 32'h0000_0044, 32'h0F0F_0F0F, 1'b0, 1'b0, 32'h0},
      '{DoGet, 32'h0000_0033, 32'h0000_0000, 1'b0, 1'b0, 32'h0}
    };

    // reset held from time zero, released on a falling edge
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      case (directed_rows[i].kind)
        DoCap: begin
          set_capacity(directed_rows[i].data[CapW-1:0]);
        end
        default: begin
          send_op((directed_rows[i].kind == DoPut) ? ModePut : ModeGet,
                  directed_rows[i].key, directed_rows[i].data, directed_rows[i].typed,
                  directed_rows[i].exp_found, directed_rows[i].exp_value);
        end
      endcase
    end

    // random phases: each at its own capacity with a fresh key pool, so gets hit,
    // updates happen and new keys push out the oldest entries
    for (p = 0; p < NumPhases; p++) begin
      cap = cap_list[p];
      if (p == 6) cap = $urandom_range(0, 31);
      set_capacity(cap);
      // every third phase runs back to back with no sender gaps
      gap_max = (p % 3 == 2) ? 0 : 6;
      pool_n  = $urandom_range(2, PoolMax);
      for (r = 0; r < PoolMax; r++) key_pool[r] = $urandom;
      for (n = 0; n < PhaseItems; n++) begin
        // mostly keys from the pool, now and then a random stray key that most likely misses
        if ($urandom_range(0, 15) == 0) k = $urandom;
        else k = key_pool[$urandom_range(0, pool_n - 1)];
        send_op($urandom_range(0, 1) ? ModePut : ModeGet, k, $urandom, 1'b0, 1'b0, '0);
      end
    end

    // drain: wait for every owed result, then watch for strays
    @(negedge clk_i);
    start_i <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk_i);
    repeat (25) @(posedge clk_i);

    $display("covered %0d get/put transfers, %0d results with %0d hits, %0d capacity writes",
             items_sent, results_seen, hits_seen, cap_writes);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/lkv_pkg.sv
rtl/core/lkv_store.sv
rtl/core/lkv_recency.sv
rtl/core/lru_key_value_cache_top.sv
test/testbench.sv
